// ===== hw/rtl/sra_pkg.sv =====
// Package for the sample record assembler: sequencer state type, result codes
// and default sizes. Used by sample_record_assembler_top; depends on nothing.
package sra_pkg;

	// Default record geometry.
	localparam int SIGNALS_DEF = 2;
	localparam int SLOTS_PER_SIGNAL_DEF = 8;

	// Request types.
	localparam logic REQ_STORE = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_SLOT    = 2'd0;
	localparam logic [1:0] KIND_HEADER  = 2'd1;
	localparam logic [1:0] KIND_OUTCOME = 2'd2;

	// Header record states.
	localparam logic [1:0] RSTATE_PUBLISHED = 2'd0;
	localparam logic [1:0] RSTATE_EMPTY     = 2'd1;
	localparam logic [1:0] RSTATE_DROPPED   = 2'd2;

	// Request outcomes.
	localparam logic [2:0] OUT_STORED_VALID   = 3'd0;
	localparam logic [2:0] OUT_STORED_INVALID = 3'd1;
	localparam logic [2:0] OUT_DUPLICATE      = 3'd2;
	localparam logic [2:0] OUT_SILENT_REPEAT  = 3'd3;
	localparam logic [2:0] OUT_LATE           = 3'd4;
	localparam logic [2:0] OUT_RANGE_OR_FLUSH = 3'd5;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PUB,
		ST_HDR,
		ST_FIN
	} state_t;

endpackage

// ===== hw/rtl/sample_record_assembler_top.sv =====
// Top level of the sample record assembler: sequencer, slot bookkeeping and
// publish path. Depends on sra_pkg and instantiates sra_ram for slot values.
//
// The receiver cannot stall this block: every result is shown on the result
// ports for exactly one cycle with strobe high and is taken at the edge that
// ends that cycle, so a receiver must capture whatever strobe marks. A
// request is taken at an edge where start is high and busy is low. A store
// into the current record, a late store, an out of range store and a flush
// of an empty record keep busy high only in the check state, which forms
// the outcome result; it leaves through the result register. A store that
// moves to a newer record, and a flush of a record whose filled signals all
// hold their final slot, walk every slot of the record through the single
// read port of the value memory, one slot per cycle, so busy stays high
// through the check state, the walk, the header and the final state: the
// slots stream out on consecutive cycles, followed by the header and the
// outcome. A flush that drops a partial record passes the check, header and
// final states (header, then outcome). Every request ends with exactly one
// outcome result carrying last. The start record register is written
// through the cfg transfer, accepted only while the block is idle; it clears
// the record without publishing it. No clearing pass runs after reset:
// present bits live in flip-flops and mask the values read from memory.
module sample_record_assembler_top #(
	parameter int SIGNALS          = sra_pkg::SIGNALS_DEF,
	parameter int SLOTS_PER_SIGNAL = sra_pkg::SLOTS_PER_SIGNAL_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request command port.
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [2:0]  signal_id,
	input  logic [31:0] record_num,
	input  logic [4:0]  sample_pos,
	input  logic        valid_in,
	input  logic [31:0] value,
	input  logic        report_dup,
	// Configuration write channel (start record).
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// Result port.
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [2:0]  slot_signal,
	output logic [4:0]  slot_sample,
	output logic        slot_present,
	output logic        slot_valid,
	output logic [31:0] slot_value,
	output logic [31:0] done_record,
	output logic [5:0]  missing_count,
	output logic [1:0]  record_state,
	output logic [31:0] empty_skipped,
	output logic [2:0]  outcome,
	output logic        last
);

	localparam int SLOT_COUNT = SIGNALS * SLOTS_PER_SIGNAL;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int SIG_W      = (SIGNALS > 1) ? $clog2(SIGNALS) : 1;

	sra_pkg::state_t state_q, state_nxt;

	// Captured request.
	logic        req_q;
	logic [2:0]  sig_q;
	logic [31:0] rec_q;
	logic [4:0]  smp_q;
	logic        vin_q;
	logic [31:0] val_q;
	logic        cdup_q;

	// Record bookkeeping.
	logic [31:0]           cur_q;
	logic [SLOT_COUNT-1:0] present_q;
	logic [SLOT_COUNT-1:0] valid_q;
	logic [SIGNALS-1:0]    any_q;
	logic [CNT_W-1:0]      filled_q;

	// Publish walk.
	logic [SLOT_W-1:0] pub_idx_q;
	logic [2:0]        pub_sig_q;
	logic [4:0]        pub_smp_q;
	logic              pub_vld_s1;
	logic [2:0]        pub_sig_s1;
	logic [4:0]        pub_smp_s1;
	logic              pub_pres_s1;
	logic              pub_valid_s1;
	logic [31:0]       ram_rdata;

	// Header and outcome result register.
	logic        out_vld_q;
	logic [1:0]  out_kind_q;
	logic [31:0] out_done_q;
	logic [5:0]  out_missing_q;
	logic [1:0]  out_rstate_q;
	logic [31:0] out_skip_q;
	logic [2:0]  out_outcome_q;
	logic        out_last_q;

	// Sequencer controls.
	logic do_fin;
	logic do_hdr;
	logic accept;
	logic cfg_wr;

	// Shared compare unit: rec + ~cur gives rec - cur - 1; its carry says rec > cur.
	logic [32:0] cmp_sum;
	logic        rec_gt;
	logic        rec_eq;
	logic        rec_late;

	logic              oor;
	logic [SLOT_W-1:0] st_idx;
	logic              st_present;
	logic              fin_store;
	logic [2:0]        fin_outcome;
	logic [CNT_W-1:0]  missing_full;
	logic [5:0]        missing_sat;
	logic [SIGNALS-1:0] last_bits;
	logic              tail_ok;
	logic              pub_last;

	assign accept = start && !busy;
	assign cfg_wr = cfg_valid && cfg_ready;

	assign cmp_sum  = {1'b0, rec_q} + {1'b0, ~cur_q};
	assign rec_gt   = cmp_sum[32];
	assign rec_eq   = (rec_q == cur_q);
	assign rec_late = !rec_gt && !rec_eq;

	assign oor    = (int'(sig_q) >= SIGNALS) || (int'(smp_q) >= SLOTS_PER_SIGNAL);
	assign st_idx = SLOT_W'(int'(sig_q) * SLOTS_PER_SIGNAL + int'(smp_q));
	assign st_present = present_q[st_idx];

	// Missing slots come from the fill count, saturated to the field width.
	assign missing_full = CNT_W'(SLOT_COUNT) - filled_q;
	assign missing_sat  = (int'(missing_full) > 63) ? 6'd63 : 6'(missing_full);

	// The tail is complete when some signal was filled and every filled signal
	// has its final slot present.
	for (genvar s = 0; s < SIGNALS; s++) begin : g_tail
		assign last_bits[s] = present_q[s * SLOTS_PER_SIGNAL + SLOTS_PER_SIGNAL - 1];
	end
	assign tail_ok = (|any_q) && ((any_q & ~last_bits) == '0);

	assign pub_last = (pub_idx_q == SLOT_W'(SLOT_COUNT - 1));

	// Finishing step shared by the check state and the final state.
	always_comb begin
		fin_store   = 1'b0;
		fin_outcome = sra_pkg::OUT_RANGE_OR_FLUSH;
		if (req_q == sra_pkg::REQ_STORE && !oor) begin
			if (rec_late) begin
				fin_outcome = sra_pkg::OUT_LATE;
			end else if (st_present) begin
				fin_outcome = cdup_q ? sra_pkg::OUT_DUPLICATE : sra_pkg::OUT_SILENT_REPEAT;
			end else begin
				fin_store   = 1'b1;
				fin_outcome = vin_q ? sra_pkg::OUT_STORED_VALID : sra_pkg::OUT_STORED_INVALID;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		do_fin    = 1'b0;
		do_hdr    = 1'b0;
		busy      = (state_q != sra_pkg::ST_IDLE);
		cfg_ready = (state_q == sra_pkg::ST_IDLE);
		case (state_q)
			sra_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = sra_pkg::ST_CHECK;
				end
			end
			sra_pkg::ST_CHECK: begin
				if (req_q == sra_pkg::REQ_FLUSH) begin
					if (filled_q == '0) begin
						do_fin    = 1'b1;
						state_nxt = sra_pkg::ST_IDLE;
					end else begin
						state_nxt = tail_ok ? sra_pkg::ST_PUB : sra_pkg::ST_HDR;
					end
				end else if (!oor && rec_gt) begin
					state_nxt = sra_pkg::ST_PUB;
				end else begin
					do_fin    = 1'b1;
					state_nxt = sra_pkg::ST_IDLE;
				end
			end
			sra_pkg::ST_PUB: begin
				if (pub_last) begin
					state_nxt = sra_pkg::ST_HDR;
				end
			end
			sra_pkg::ST_HDR: begin
				do_hdr    = 1'b1;
				state_nxt = sra_pkg::ST_FIN;
			end
			sra_pkg::ST_FIN: begin
				do_fin    = 1'b1;
				state_nxt = sra_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = sra_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sra_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_type;
			sig_q  <= signal_id;
			rec_q  <= record_num;
			smp_q  <= sample_pos;
			vin_q  <= valid_in;
			val_q  <= value;
			cdup_q <= report_dup;
		end
	end

	// Record state: cleared by a start record write and after every header.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			present_q <= '0;
			valid_q   <= '0;
			any_q     <= '0;
			filled_q  <= '0;
		end else if (cfg_wr) begin
			cur_q     <= cfg_data;
			present_q <= '0;
			valid_q   <= '0;
			any_q     <= '0;
			filled_q  <= '0;
		end else if (do_hdr) begin
			present_q <= '0;
			valid_q   <= '0;
			any_q     <= '0;
			filled_q  <= '0;
			if (req_q == sra_pkg::REQ_STORE) begin
				cur_q <= rec_q;
			end
		end else if (do_fin && fin_store) begin
			present_q[st_idx]           <= 1'b1;
			valid_q[st_idx]             <= vin_q;
			any_q[sig_q[SIG_W-1:0]]     <= 1'b1;
			filled_q                    <= filled_q + CNT_W'(1);
		end
	end

	// Publish walk counters; they restart whenever the check state runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pub_idx_q  <= '0;
			pub_sig_q  <= '0;
			pub_smp_q  <= '0;
			pub_vld_s1 <= 1'b0;
		end else begin
			pub_vld_s1 <= (state_q == sra_pkg::ST_PUB);
			if (state_q == sra_pkg::ST_CHECK) begin
				pub_idx_q <= '0;
				pub_sig_q <= '0;
				pub_smp_q <= '0;
			end else if (state_q == sra_pkg::ST_PUB) begin
				pub_idx_q <= pub_idx_q + SLOT_W'(1);
				if (pub_smp_q == 5'(SLOTS_PER_SIGNAL - 1)) begin
					pub_smp_q <= '0;
					pub_sig_q <= pub_sig_q + 3'd1;
				end else begin
					pub_smp_q <= pub_smp_q + 5'd1;
				end
			end
		end
	end

	// Slot position and bits travel alongside the memory read.
	always_ff @(posedge clk) begin
		pub_sig_s1   <= pub_sig_q;
		pub_smp_s1   <= pub_smp_q;
		pub_pres_s1  <= present_q[pub_idx_q];
		pub_valid_s1 <= valid_q[pub_idx_q];
	end

	sra_ram #(
		.WIDTH (32),
		.DEPTH (SLOT_COUNT)
	) u_values (
		.clk   (clk),
		.we    (do_fin && fin_store),
		.waddr (st_idx),
		.wdata (val_q),
		.raddr (pub_idx_q),
		.rdata (ram_rdata)
	);

	// Header and outcome results leave from one register, in the cycle after they
	// are formed, so they never meet the last published slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= do_hdr || do_fin;
		end
	end

	always_ff @(posedge clk) begin
		if (do_hdr) begin
			out_kind_q    <= sra_pkg::KIND_HEADER;
			out_done_q    <= cur_q;
			out_missing_q <= missing_sat;
			out_outcome_q <= '0;
			out_last_q    <= 1'b0;
			if (req_q == sra_pkg::REQ_FLUSH) begin
				out_rstate_q <= tail_ok ? sra_pkg::RSTATE_PUBLISHED : sra_pkg::RSTATE_DROPPED;
				out_skip_q   <= '0;
			end else begin
				out_rstate_q <= (filled_q != '0) ? sra_pkg::RSTATE_PUBLISHED
					: sra_pkg::RSTATE_EMPTY;
				out_skip_q   <= cmp_sum[31:0];
			end
		end else if (do_fin) begin
			out_kind_q    <= sra_pkg::KIND_OUTCOME;
			out_done_q    <= '0;
			out_missing_q <= '0;
			out_rstate_q  <= '0;
			out_skip_q    <= '0;
			out_outcome_q <= fin_outcome;
			out_last_q    <= 1'b1;
		end
	end

	always_comb begin
		strobe = pub_vld_s1 || out_vld_q;
		if (pub_vld_s1) begin
			kind          = sra_pkg::KIND_SLOT;
			slot_signal   = pub_sig_s1;
			slot_sample   = pub_smp_s1;
			slot_present  = pub_pres_s1;
			slot_valid    = pub_valid_s1;
			slot_value    = pub_pres_s1 ? ram_rdata : 32'd0;
			done_record   = '0;
			missing_count = '0;
			record_state  = '0;
			empty_skipped = '0;
			outcome       = '0;
			last          = 1'b0;
		end else begin
			kind          = out_kind_q;
			slot_signal   = '0;
			slot_sample   = '0;
			slot_present  = 1'b0;
			slot_valid    = 1'b0;
			slot_value    = '0;
			done_record   = out_done_q;
			missing_count = out_missing_q;
			record_state  = out_rstate_q;
			empty_skipped = out_skip_q;
			outcome       = out_outcome_q;
			last          = out_last_q;
		end
	end

endmodule

// ===== hw/rtl/sra_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the slot value store of the sample record assembler.
module sra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
